>>> rtl/fbreg_pkg.sv
// Shared constants, register map and helper functions of the framebuffer card register block.
package fbreg_pkg;

  // Card geometry and store sizes
  localparam int FRAMESTORE_BYTES = 16252928;
  localparam int MAX_MODE_WIDTH   = 2560;
  localparam int MAX_MODE_HEIGHT  = 1440;
  localparam int EDID_BYTES       = 128;
  localparam int PAL_DEPTH        = 256;

  // Derived widths
  localparam int PAL_AW  = $clog2(PAL_DEPTH);
  localparam int EDID_AW = $clog2(EDID_BYTES);
  localparam int EDID_PW = $clog2(EDID_BYTES + 1);
  localparam int HM1_W   = $clog2(MAX_MODE_HEIGHT);
  localparam int WID_W   = $clog2(MAX_MODE_WIDTH + 1);
  localparam int ROWB_W  = WID_W + 2;
  localparam int PROD_W  = 32 + HM1_W;
  localparam int NEED_W  = PROD_W + 1;

  // Commands
  localparam logic [1:0] CMD_READ      = 2'd0;
  localparam logic [1:0] CMD_WRITE     = 2'd1;
  localparam logic [1:0] CMD_VSYNC     = 2'd2;
  localparam logic [1:0] CMD_EDID_LOAD = 2'd3;

  // Register map
  localparam logic [4:0] REG_ID        = 5'd0;
  localparam logic [4:0] REG_VERSION   = 5'd1;
  localparam logic [4:0] REG_CAPS      = 5'd2;
  localparam logic [4:0] REG_FB_BASE   = 5'd3;
  localparam logic [4:0] REG_FB_SIZE   = 5'd4;
  localparam logic [4:0] REG_CONTROL   = 5'd5;
  localparam logic [4:0] REG_STATUS    = 5'd6;
  localparam logic [4:0] REG_WIDTH     = 5'd7;
  localparam logic [4:0] REG_HEIGHT    = 5'd8;
  localparam logic [4:0] REG_DEPTH     = 5'd9;
  localparam logic [4:0] REG_STRIDE    = 5'd10;
  localparam logic [4:0] REG_START     = 5'd11;
  localparam logic [4:0] REG_PAL_PTR   = 5'd12;
  localparam logic [4:0] REG_PAL_DATA  = 5'd13;
  localparam logic [4:0] REG_MAX_W     = 5'd14;
  localparam logic [4:0] REG_MAX_H     = 5'd15;
  localparam logic [4:0] REG_FRAMES    = 5'd16;
  localparam logic [4:0] REG_EDID_SIZE = 5'd17;
  localparam logic [4:0] REG_EDID_PTR  = 5'd18;
  localparam logic [4:0] REG_EDID_DATA = 5'd19;

  // Configuration register indexes
  localparam logic [1:0] CFG_EDID_PRESENT = 2'd0;
  localparam logic [1:0] CFG_FB_BASE      = 2'd1;
  localparam logic [1:0] CFG_CARD_ID      = 2'd2;
  localparam logic [1:0] CFG_CARD_VERSION = 2'd3;

  // Control bit positions
  localparam int CTL_ENABLE    = 0;
  localparam int CTL_BLANK     = 1;
  localparam int CTL_VSYNC_IRQ = 2;

  // Capability word
  localparam logic [31:0] CAP_BASE = 32'h0000_000F;
  localparam logic [31:0] CAP_EDID = 32'h0000_0010;

  // Palette entry after reset: index replicated in bytes 1..3
  function automatic logic [31:0] pal_ramp(input logic [PAL_AW-1:0] idx);
    logic [7:0] b;
    b = 8'(idx);
    return {b, b, b, 8'h00};
  endfunction

endpackage

>>> rtl/fbreg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbreg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/framebuffer_card_register_block.sv
// Top level of the framebuffer card register block: command pipeline, registers, palette, EDID.
//
//  channel | dir | signals                          | word
//  --------+-----+----------------------------------+--------------------------------------
//  in      | in  | in_tvalid/in_tready/in_tdata/tuser| tuser: command; tdata: see port list
//  out     | out | out_tvalid/out_tready/out_tdata  | read_data, irq, frame_valid, blanked
//  cfg     | in  | cfg_we/cfg_index/cfg_wdata        | write only, taken every cycle
//
//  One word per cycle while out_tready stays high; an accepted word passes the input register,
//  command stage, mode multiply stage and result register before its result shows on out_tvalid.
//  The 32x11 stride multiply of the frame check is the widest path; it has its own stage.
//  Reset (rst_n low, synchronous) clears control state; palette entries read as the grey
//  ramp through per-entry valid flags, so no clearing pass is needed.
//  out_tready low holds the result word; the stages behind it fill, then in_tready drops.
module framebuffer_card_register_block
  import fbreg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [4:0] reg_index, [36:5] write_data, [43:37] edid_load_index, [47:44] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  // in_tuser: [1:0] command
  input  logic [1:0]  in_tuser,
  // out_tdata: [31:0] read_data, [32] irq, [33] frame_valid, [34] blanked, [39:35] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  // configuration registers
  logic        edid_present_r;
  logic [31:0] fb_base_r;
  logic [31:0] card_id_r;
  logic [31:0] card_ver_r;

  // input stage
  logic        a_v_r;
  logic [1:0]  a_cmd_r;
  logic [4:0]  a_reg_r;
  logic [31:0] a_data_r;
  logic [6:0]  a_li_r;

  // card state
  logic [2:0]          ctl_r,      ctl_nxt;
  logic                pend_r,     pend_nxt;
  logic                irq_r,      irq_nxt;
  logic [31:0]         width_r,    width_nxt;
  logic [31:0]         height_r,   height_nxt;
  logic [31:0]         depth_r,    depth_nxt;
  logic [31:0]         stride_r,   stride_nxt;
  logic [31:0]         start_r,    start_nxt;
  logic [PAL_AW-1:0]   pal_ptr_r,  pal_ptr_nxt;
  logic [PAL_DEPTH-1:0] pal_vld_r, pal_vld_nxt;
  logic [31:0]         frames_r,   frames_nxt;
  logic [EDID_PW-1:0]  edid_ptr_r, edid_ptr_nxt;
  logic                edid_byp_v_r, edid_byp_v_nxt;
  logic [7:0]          edid_byp_d_r;

  // command stage result
  logic        b_v_r;
  logic [31:0] b_rd_r;
  logic        b_irq_r;
  logic        b_blank_r;

  // frame check stage
  logic              c_v_r;
  logic [31:0]       c_rd_r;
  logic              c_irq_r;
  logic              c_blank_r;
  logic              c_pre_ok_r;
  logic [PROD_W-1:0] c_prod_r;
  logic [ROWB_W-1:0] c_rowb_r;
  logic [31:0]       c_limit_r;

  // result register
  logic        o_v_r;
  logic [31:0] o_rd_r;
  logic        o_irq_r;
  logic        o_fv_r;
  logic        o_blank_r;

  // handshake
  logic o_free, c_free, b_free, a_go, in_acc;

  // memories
  logic              pal_we;
  logic [31:0]       pal_rdata;
  logic              edid_we;
  logic [EDID_AW-1:0] edid_waddr, edid_raddr;
  logic [7:0]        edid_rdata;

  // read data and frame check terms
  logic [31:0]       rd_val, rd_nxt;
  logic [31:0]       pal_word;
  logic [7:0]        edid_byte;
  logic              edid_in_range;
  logic [31:0]       hm1;
  logic [ROWB_W-1:0] rowb;
  logic              pre_ok;
  logic [NEED_W-1:0] need;

  // ---------------------------------------------------------------- handshake
  assign o_free    = !o_v_r || out_tready;
  assign c_free    = !c_v_r || o_free;
  assign b_free    = !b_v_r || c_free;
  assign a_go      = a_v_r && b_free;
  assign in_tready = !a_v_r || b_free;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (in_acc) a_v_r <= 1'b1;
      else if (a_go) a_v_r <= 1'b0;
      if (a_go) b_v_r <= 1'b1;
      else if (c_free) b_v_r <= 1'b0;
      if (b_v_r && c_free) c_v_r <= 1'b1;
      else if (o_free) c_v_r <= 1'b0;
      if (c_v_r && o_free) o_v_r <= 1'b1;
      else if (out_tready) o_v_r <= 1'b0;
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_cmd_r  <= in_tuser;
      a_reg_r  <= in_tdata[4:0];
      a_data_r <= in_tdata[36:5];
      a_li_r   <= in_tdata[43:37];
    end
  end

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edid_present_r <= 1'b0;
      fb_base_r      <= '0;
      card_id_r      <= '0;
      card_ver_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EDID_PRESENT: edid_present_r <= cfg_wdata[0];
        CFG_FB_BASE:      fb_base_r      <= cfg_wdata;
        CFG_CARD_ID:      card_id_r      <= cfg_wdata;
        CFG_CARD_VERSION: card_ver_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- memories
  // read address tracks the next pointer, so data lines up with the pointer register
  fbreg_ram #(.WIDTH(32), .DEPTH(PAL_DEPTH)) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_ptr_r),
    .wdata (a_data_r),
    .raddr (pal_ptr_nxt),
    .rdata (pal_rdata)
  );

  assign edid_raddr = edid_ptr_nxt[EDID_AW-1:0];

  fbreg_ram #(.WIDTH(8), .DEPTH(EDID_BYTES)) u_edid_ram (
    .clk   (clk),
    .we    (edid_we),
    .waddr (edid_waddr),
    .wdata (a_data_r[7:0]),
    .raddr (edid_raddr),
    .rdata (edid_rdata)
  );

  // a load at the pointer's own entry is forwarded past the RAM
  assign edid_byp_v_nxt = edid_we && (edid_waddr == edid_raddr);

  assign pal_word  = pal_vld_r[pal_ptr_r] ? pal_rdata : pal_ramp(pal_ptr_r);
  assign edid_byte = edid_byp_v_r ? edid_byp_d_r : edid_rdata;
  assign edid_in_range = edid_ptr_r < EDID_PW'(EDID_BYTES);

  // ---------------------------------------------------------------- register read mux
  always_comb begin
    rd_val = '0;
    case (a_reg_r)
      REG_ID:        rd_val = card_id_r;
      REG_VERSION:   rd_val = card_ver_r;
      REG_CAPS:      rd_val = CAP_BASE | (edid_present_r ? CAP_EDID : 32'd0);
      REG_FB_BASE:   rd_val = fb_base_r;
      REG_FB_SIZE:   rd_val = 32'(FRAMESTORE_BYTES);
      REG_CONTROL:   rd_val = 32'(ctl_r);
      REG_STATUS:    rd_val = 32'(pend_r);
      REG_WIDTH:     rd_val = width_r;
      REG_HEIGHT:    rd_val = height_r;
      REG_DEPTH:     rd_val = depth_r;
      REG_STRIDE:    rd_val = stride_r;
      REG_START:     rd_val = start_r;
      REG_PAL_PTR:   rd_val = 32'(pal_ptr_r);
      REG_PAL_DATA:  rd_val = pal_word;
      REG_MAX_W:     rd_val = 32'(MAX_MODE_WIDTH);
      REG_MAX_H:     rd_val = 32'(MAX_MODE_HEIGHT);
      REG_FRAMES:    rd_val = frames_r;
      REG_EDID_SIZE: rd_val = edid_present_r ? 32'(EDID_BYTES) : 32'd0;
      REG_EDID_PTR:  rd_val = 32'(edid_ptr_r);
      REG_EDID_DATA: rd_val = (edid_in_range && edid_present_r) ? 32'(edid_byte) : 32'd0;
      default:       rd_val = '0;
    endcase
  end

  // ---------------------------------------------------------------- command execution
  always_comb begin
    ctl_nxt      = ctl_r;
    pend_nxt     = pend_r;
    irq_nxt      = irq_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    depth_nxt    = depth_r;
    stride_nxt   = stride_r;
    start_nxt    = start_r;
    pal_ptr_nxt  = pal_ptr_r;
    pal_vld_nxt  = pal_vld_r;
    frames_nxt   = frames_r;
    edid_ptr_nxt = edid_ptr_r;
    pal_we       = 1'b0;
    edid_we      = 1'b0;
    edid_waddr   = EDID_AW'(a_li_r);
    rd_nxt       = '0;
    if (a_go) begin
      case (a_cmd_r)
        CMD_READ: begin
          rd_nxt = rd_val;
          // data read steps the EDID pointer until it sticks at the end
          if (a_reg_r == REG_EDID_DATA && edid_in_range) begin
            edid_ptr_nxt = edid_ptr_r + EDID_PW'(1);
          end
        end
        CMD_WRITE: begin
          case (a_reg_r)
            REG_CONTROL: begin
              ctl_nxt = a_data_r[2:0];
              if (!a_data_r[CTL_VSYNC_IRQ]) begin
                pend_nxt = 1'b0;
                irq_nxt  = 1'b0;
              end
            end
            REG_STATUS: begin
              // write-to-clear
              pend_nxt = pend_r & ~a_data_r[0];
              if (!(pend_r & ~a_data_r[0])) irq_nxt = 1'b0;
            end
            REG_WIDTH:   width_nxt  = a_data_r;
            REG_HEIGHT:  height_nxt = a_data_r;
            REG_DEPTH:   depth_nxt  = a_data_r;
            REG_STRIDE:  stride_nxt = a_data_r;
            REG_START:   start_nxt  = a_data_r;
            REG_PAL_PTR: pal_ptr_nxt = a_data_r[PAL_AW-1:0];
            REG_PAL_DATA: begin
              pal_we                 = 1'b1;
              pal_vld_nxt[pal_ptr_r] = 1'b1;
              pal_ptr_nxt            = pal_ptr_r + PAL_AW'(1);
            end
            REG_EDID_PTR: begin
              edid_ptr_nxt = (a_data_r < 32'(EDID_BYTES)) ? EDID_PW'(a_data_r)
                                                          : EDID_PW'(EDID_BYTES);
            end
            default: ;
          endcase
        end
        CMD_VSYNC: begin
          if (ctl_r[CTL_ENABLE]) begin
            frames_nxt = frames_r + 32'd1;
            pend_nxt   = 1'b1;
            if (ctl_r[CTL_VSYNC_IRQ]) irq_nxt = 1'b1;
          end
        end
        CMD_EDID_LOAD: begin
          if (32'(a_li_r) < 32'(EDID_BYTES)) edid_we = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r        <= '0;
      pend_r       <= 1'b0;
      irq_r        <= 1'b0;
      width_r      <= '0;
      height_r     <= '0;
      depth_r      <= '0;
      stride_r     <= '0;
      start_r      <= '0;
      pal_ptr_r    <= '0;
      pal_vld_r    <= '0;
      frames_r     <= '0;
      edid_ptr_r   <= '0;
      edid_byp_v_r <= 1'b0;
    end else begin
      ctl_r        <= ctl_nxt;
      pend_r       <= pend_nxt;
      irq_r        <= irq_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      depth_r      <= depth_nxt;
      stride_r     <= stride_nxt;
      start_r      <= start_nxt;
      pal_ptr_r    <= pal_ptr_nxt;
      pal_vld_r    <= pal_vld_nxt;
      frames_r     <= frames_nxt;
      edid_ptr_r   <= edid_ptr_nxt;
      edid_byp_v_r <= edid_byp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    edid_byp_d_r <= a_data_r[7:0];
  end

  // command stage result: state after the word
  always_ff @(posedge clk) begin
    if (a_go) begin
      b_rd_r    <= rd_nxt;
      b_irq_r   <= irq_nxt;
      b_blank_r <= ctl_nxt[CTL_BLANK];
    end
  end

  // ---------------------------------------------------------------- frame check
  // while a word sits in the command-result stage the mode registers hold its state
  assign hm1  = height_r - 32'd1;
  assign rowb = (depth_r == 32'd32) ? {width_r[WID_W-1:0], 2'b00}
                                    : {2'b00, width_r[WID_W-1:0]};
  assign pre_ok = ctl_r[CTL_ENABLE] &&
                  (width_r != 32'd0) && (height_r != 32'd0) && (stride_r != 32'd0) &&
                  ((depth_r == 32'd8) || (depth_r == 32'd32)) &&
                  (width_r <= 32'(MAX_MODE_WIDTH)) && (height_r <= 32'(MAX_MODE_HEIGHT)) &&
                  (stride_r >= 32'(rowb)) && (start_r < 32'(FRAMESTORE_BYTES));

  always_ff @(posedge clk) begin
    if (b_v_r && c_free) begin
      c_rd_r     <= b_rd_r;
      c_irq_r    <= b_irq_r;
      c_blank_r  <= b_blank_r;
      c_pre_ok_r <= pre_ok;
      c_prod_r   <= PROD_W'(stride_r) * PROD_W'(hm1[HM1_W-1:0]);
      c_rowb_r   <= rowb;
      c_limit_r  <= 32'(FRAMESTORE_BYTES) - start_r;
    end
  end

  // bytes spanned by the frame against room left after the start offset
  assign need = NEED_W'(c_prod_r) + NEED_W'(c_rowb_r);

  always_ff @(posedge clk) begin
    if (c_v_r && o_free) begin
      o_rd_r    <= c_rd_r;
      o_irq_r   <= c_irq_r;
      o_blank_r <= c_blank_r;
      o_fv_r    <= c_pre_ok_r && (need <= NEED_W'(c_limit_r));
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = {5'd0, o_blank_r, o_fv_r, o_irq_r, o_rd_r};

  // ---------------------------------------------------------------- assertions
  a_edid_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edid_ptr_r <= EDID_PW'(EDID_BYTES))
    else $error("EDID pointer past end of store");

  a_irq_pending: assert property (@(posedge clk) disable iff (!rst_n)
    irq_r |-> pend_r)
    else $error("irq raised with no vsync pending");

  a_irq_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    irq_r |-> ctl_r[CTL_VSYNC_IRQ])
    else $error("irq raised with vsync interrupt disabled");

  a_pal_step: assert property (@(posedge clk) disable iff (!rst_n)
    (a_go && a_cmd_r == CMD_WRITE && a_reg_r == REG_PAL_DATA)
      |=> (pal_ptr_r == $past(pal_ptr_r) + PAL_AW'(1)))
    else $error("palette pointer did not step after entry write");

endmodule

>>> test/framebuffer_card_register_block_test.sv
// Self-checking testbench of the framebuffer card register block: stimulus, mirror, checks.
import fbreg_pkg::*;

// One reply word as the block reports it
typedef struct packed {
  logic [31:0] read_data;
  logic        irq;
  logic        frame_valid;
  logic        blanked;
} card_reply_t;

// Mirror of the card registers; predicts the reply of every accepted command word
class card_reg_mirror;
  // configuration
  bit          edid_present;
  bit [31:0]   fb_base;
  bit [31:0]   card_id;
  bit [31:0]   card_version;
  // register state
  bit [2:0]    control;
  bit          vsync_pending;
  bit          irq_level;
  bit [31:0]   mode_width;
  bit [31:0]   mode_height;
  bit [31:0]   mode_depth;
  bit [31:0]   row_stride;
  bit [31:0]   display_start;
  bit [31:0]   frame_count;
  bit [7:0]    pal_ptr;
  bit [31:0]   palette [PAL_DEPTH];
  bit [7:0]    edid_ptr;
  bit [7:0]    edid_bytes [EDID_BYTES];
  bit          edid_loaded [EDID_BYTES];
  // replies still owed by the block, oldest first
  card_reply_t pending_replies [$];
  int          errors;

  function new();
    for (int i = 0; i < PAL_DEPTH; i++) begin
      palette[i] = {8'(i), 8'(i), 8'(i), 8'h00};
    end
    for (int i = 0; i < EDID_BYTES; i++) begin
      edid_loaded[i] = 1'b0;
    end
  endfunction

  function void set_config(logic [1:0] idx, logic [31:0] value);
    case (idx)
      CFG_EDID_PRESENT: edid_present = value[0];
      CFG_FB_BASE:      fb_base = value;
      CFG_CARD_ID:      card_id = value;
      CFG_CARD_VERSION: card_version = value;
      default: ;
    endcase
  endfunction

  // A data read may only touch a byte that a load has written
  function bit edid_read_safe();
    return edid_ptr >= EDID_BYTES || edid_loaded[edid_ptr];
  endfunction

  function bit frame_displayable();
    longint unsigned row_bytes;
    longint unsigned needed;
    if (!control[CTL_ENABLE]) return 1'b0;
    if (mode_width == 0 || mode_height == 0 || row_stride == 0) return 1'b0;
    if (mode_depth != 8 && mode_depth != 32) return 1'b0;
    if (mode_width > 32'(MAX_MODE_WIDTH) || mode_height > 32'(MAX_MODE_HEIGHT)) return 1'b0;
    row_bytes = 64'(mode_width) * 64'(mode_depth >> 3);
    if (64'(row_stride) < row_bytes) return 1'b0;
    if (display_start >= 32'(FRAMESTORE_BYTES)) return 1'b0;
    needed = 64'(row_stride) * 64'(mode_height - 32'd1) + row_bytes;
    if (needed > 64'(32'(FRAMESTORE_BYTES) - display_start)) return 1'b0;
    return 1'b1;
  endfunction

  function bit [31:0] read_reg(logic [4:0] r);
    bit [31:0] v;
    case (r)
      REG_ID:        return card_id;
      REG_VERSION:   return card_version;
      REG_CAPS:      return CAP_BASE | (edid_present ? CAP_EDID : 32'd0);
      REG_FB_BASE:   return fb_base;
      REG_FB_SIZE:   return 32'(FRAMESTORE_BYTES);
      REG_CONTROL:   return {29'd0, control};
      REG_STATUS:    return {31'd0, vsync_pending};
      REG_WIDTH:     return mode_width;
      REG_HEIGHT:    return mode_height;
      REG_DEPTH:     return mode_depth;
      REG_STRIDE:    return row_stride;
      REG_START:     return display_start;
      REG_PAL_PTR:   return {24'd0, pal_ptr};
      REG_PAL_DATA:  return palette[pal_ptr];
      REG_MAX_W:     return 32'(MAX_MODE_WIDTH);
      REG_MAX_H:     return 32'(MAX_MODE_HEIGHT);
      REG_FRAMES:    return frame_count;
      REG_EDID_SIZE: return edid_present ? 32'(EDID_BYTES) : 32'd0;
      REG_EDID_PTR:  return {24'd0, edid_ptr};
      REG_EDID_DATA: begin
        // pointer steps on even with no monitor data, sticks at the end
        v = 32'd0;
        if (edid_ptr < EDID_BYTES) begin
          if (edid_present) v = {24'd0, edid_bytes[edid_ptr]};
          edid_ptr++;
        end
        return v;
      end
      default:       return 32'd0;
    endcase
  endfunction

  function void write_reg(logic [4:0] r, logic [31:0] data);
    case (r)
      REG_CONTROL: begin
        control = data[2:0];
        if (!control[CTL_VSYNC_IRQ]) begin
          vsync_pending = 1'b0;
          irq_level = 1'b0;
        end
      end
      REG_STATUS: begin
        vsync_pending = vsync_pending & ~data[0];
        if (!vsync_pending) irq_level = 1'b0;
      end
      REG_WIDTH:    mode_width = data;
      REG_HEIGHT:   mode_height = data;
      REG_DEPTH:    mode_depth = data;
      REG_STRIDE:   row_stride = data;
      REG_START:    display_start = data;
      REG_PAL_PTR:  pal_ptr = data[7:0];
      REG_PAL_DATA: begin
        palette[pal_ptr] = data;
        pal_ptr++;
      end
      REG_EDID_PTR: edid_ptr = (data < EDID_BYTES) ? data[7:0] : 8'(EDID_BYTES);
      default: ;
    endcase
  endfunction

  // Called for every accepted input word
  function void take_command(logic [1:0] cmd, logic [4:0] r, logic [31:0] data,
                             logic [6:0] li);
    card_reply_t rep;
    rep.read_data = 32'd0;
    case (cmd)
      CMD_READ:  rep.read_data = read_reg(r);
      CMD_WRITE: write_reg(r, data);
      CMD_VSYNC: begin
        if (control[CTL_ENABLE]) begin
          frame_count++;
          vsync_pending = 1'b1;
          if (control[CTL_VSYNC_IRQ]) irq_level = 1'b1;
        end
      end
      CMD_EDID_LOAD: begin
        edid_bytes[li] = data[7:0];
        edid_loaded[li] = 1'b1;
      end
      default: ;
    endcase
    rep.irq = irq_level;
    rep.frame_valid = frame_displayable();
    rep.blanked = control[CTL_BLANK];
    pending_replies.push_back(rep);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Called for every accepted output word
  function void check_reply(logic [39:0] word);
    card_reply_t want;
    if (pending_replies.size() == 0) begin
      errors++;
      $display("%0t: reply word %h with none expected, expected nothing, actual %h",
               $time, word, word);
      return;
    end
    want = pending_replies.pop_front();
    compare_field("read_data", want.read_data, word[31:0]);
    compare_field("irq", 32'(want.irq), 32'(word[32]));
    compare_field("frame_valid", 32'(want.frame_valid), 32'(word[33]));
    compare_field("blanked", 32'(want.blanked), 32'(word[34]));
  endfunction

  function int owed();
    return pending_replies.size();
  endfunction
endclass

module framebuffer_card_register_block_test;
  import fbreg_pkg::*;

  localparam int PIPE_LATENCY   = 4;
  localparam int HOLD_CYCLES    = 80;
  localparam int TIMEOUT_CYCLES = 500000;
  localparam int PHASE_WORDS    = 410;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  card_reg_mirror mirror = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_asks   = 0;
  int words_sent  = 0;

  framebuffer_card_register_block dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < TIMEOUT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: check accepted words, random back-pressure, long hold on request
  initial begin : reply_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) mirror.check_reply(out_tdata);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Offer one command word, wait for it to be taken, then note it in the mirror
  task automatic send_word(logic [1:0] cmd, logic [4:0] r, logic [31:0] data, logic [6:0] li);
    // never read a monitor byte that no load has written: load it instead
    if (cmd == CMD_READ && r == REG_EDID_DATA && !mirror.edid_read_safe()) begin
      cmd = CMD_EDID_LOAD;
      li = mirror.edid_ptr[6:0];
    end
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, li, data, r};
    in_tuser <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mirror.take_command(cmd, r, data, li);
    words_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (mirror.owed() != 0) @(posedge clk);
  endtask

  // Write all four configuration registers on back-to-back cycles
  task automatic write_config(logic present, logic [31:0] base, logic [31:0] id,
                              logic [31:0] version);
    logic [1:0]  idx  [4];
    logic [31:0] vals [4];
    idx  = '{CFG_EDID_PRESENT, CFG_FB_BASE, CFG_CARD_ID, CFG_CARD_VERSION};
    vals = '{{31'd0, present}, base, id, version};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      mirror.set_config(idx[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [6:0] rand_li();
    return 7'($urandom_range(0, 127));
  endfunction

  // Write data biased toward the interesting range of each register
  function automatic logic [31:0] pick_value(logic [4:0] r);
    logic [31:0] raw;
    raw = $urandom;
    if ($urandom_range(0, 3) == 0) return raw;
    case (r)
      REG_CONTROL: return {29'd0, raw[2:0]};
      REG_STATUS:  return {31'd0, raw[0]};
      REG_WIDTH:   return $urandom_range(0, MAX_MODE_WIDTH + 2);
      REG_HEIGHT:  return $urandom_range(0, MAX_MODE_HEIGHT + 2);
      REG_DEPTH: begin
        case (raw[2:0])
          3'd0:    return 32'd0;
          3'd1:    return 32'd16;
          3'd2:    return 32'd24;
          3'd3,
          3'd4:    return 32'd8;
          default: return 32'd32;
        endcase
      end
      REG_STRIDE:   return $urandom_range(0, 12000);
      REG_START: begin
        if (raw[0]) return $urandom_range(FRAMESTORE_BYTES - 2, FRAMESTORE_BYTES + 1);
        return $urandom_range(0, 65536);
      end
      REG_EDID_PTR: return $urandom_range(0, 2 * EDID_BYTES);
      default:      return raw;
    endcase
  endfunction

  // Full mode setup with a geometry that often lands on the framestore boundary
  task automatic mode_sequence();
    int              w;
    int              h;
    int              bpp;
    int              s;
    longint unsigned need;
    logic [31:0]     st;
    logic [31:0]     ctl;
    w = $urandom_range(1, MAX_MODE_WIDTH + 4);
    h = $urandom_range(1, MAX_MODE_HEIGHT + 4);
    bpp = ($urandom_range(0, 2) == 0) ? 1 : 4;
    s = w * bpp + (($urandom_range(0, 5) == 0) ? -1 : $urandom_range(0, 64));
    need = 64'(s) * 64'(h - 1) + 64'(w * bpp);
    if (need <= 64'(FRAMESTORE_BYTES)) begin
      case ($urandom_range(0, 3))
        0:       st = 32'(64'(FRAMESTORE_BYTES) - need);
        1:       st = 32'(64'(FRAMESTORE_BYTES) - need + 64'd1);
        default: st = $urandom_range(0, 32'(64'(FRAMESTORE_BYTES) - need));
      endcase
    end else begin
      st = $urandom_range(0, FRAMESTORE_BYTES);
    end
    ctl = $urandom;
    if ($urandom_range(0, 7) != 0) ctl[CTL_ENABLE] = 1'b1;
    send_word(CMD_WRITE, REG_CONTROL, ctl, rand_li());
    send_word(CMD_WRITE, REG_WIDTH, 32'(w), rand_li());
    send_word(CMD_WRITE, REG_HEIGHT, 32'(h), rand_li());
    send_word(CMD_WRITE, REG_DEPTH, 32'(bpp * 8), rand_li());
    send_word(CMD_WRITE, REG_STRIDE, 32'(s), rand_li());
    send_word(CMD_WRITE, REG_START, st, rand_li());
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 1) == 0) send_word(CMD_VSYNC, 5'($urandom), $urandom, rand_li());
      else send_word(CMD_READ, 5'($urandom_range(0, 19)), $urandom, rand_li());
    end
  endtask

  task automatic palette_burst();
    send_word(CMD_WRITE, REG_PAL_PTR, $urandom, rand_li());
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 1) == 0) send_word(CMD_WRITE, REG_PAL_DATA, $urandom, rand_li());
      else send_word(CMD_READ, REG_PAL_DATA, $urandom, rand_li());
    end
    send_word(CMD_READ, REG_PAL_PTR, $urandom, rand_li());
  endtask

  task automatic edid_burst();
    logic [31:0] ptr;
    repeat ($urandom_range(1, 4)) send_word(CMD_EDID_LOAD, 5'($urandom), $urandom, rand_li());
    case ($urandom_range(0, 3))
      0:       ptr = 32'(EDID_BYTES);
      1:       ptr = $urandom_range(EDID_BYTES + 1, 2 * EDID_BYTES);
      2:       ptr = $urandom;
      default: ptr = $urandom_range(0, EDID_BYTES - 1);
    endcase
    send_word(CMD_WRITE, REG_EDID_PTR, ptr, rand_li());
    repeat ($urandom_range(1, 5)) send_word(CMD_READ, REG_EDID_DATA, $urandom, rand_li());
    send_word(CMD_READ, REG_EDID_PTR, $urandom, rand_li());
  endtask

  task automatic vsync_burst();
    logic [31:0] ctl;
    ctl = $urandom;
    if ($urandom_range(0, 4) != 0) ctl[CTL_ENABLE] = 1'b1;
    send_word(CMD_WRITE, REG_CONTROL, ctl, rand_li());
    repeat ($urandom_range(1, 3)) send_word(CMD_VSYNC, 5'($urandom), $urandom, rand_li());
    send_word(CMD_READ, REG_STATUS, $urandom, rand_li());
    send_word(CMD_WRITE, REG_STATUS, $urandom, rand_li());
    send_word(CMD_READ, REG_CONTROL, $urandom, rand_li());
    send_word(CMD_READ, REG_FRAMES, $urandom, rand_li());
  endtask

  task automatic random_word();
    logic [4:0] r;
    r = 5'($urandom);
    send_word(2'($urandom_range(0, 3)), r, pick_value(r), rand_li());
  endtask

  task automatic run_random(int count);
    int target;
    target = words_sent + count;
    while (words_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: mode_sequence();
        3:       palette_burst();
        4:       edid_burst();
        5:       vsync_burst();
        default: random_word();
      endcase
    end
  endtask

  task automatic run_directed();
    // identity, unused and read-only registers
    send_word(CMD_READ, REG_ID, 32'd0, 7'd0);
    send_word(CMD_READ, REG_CAPS, 32'd0, 7'd0);
    send_word(CMD_READ, 5'd31, 32'd0, 7'd0);
    send_word(CMD_WRITE, 5'd31, 32'hFFFF_FFFF, 7'd0);
    send_word(CMD_WRITE, REG_ID, 32'hFFFF_FFFF, 7'd0);
    send_word(CMD_READ, REG_ID, 32'd0, 7'd0);
    // palette ramp after reset, pointer wrap
    send_word(CMD_READ, REG_PAL_DATA, 32'd0, 7'd0);
    send_word(CMD_WRITE, REG_PAL_PTR, 32'hFFFF_FFFF, 7'd0);
    send_word(CMD_READ, REG_PAL_DATA, 32'd0, 7'd0);
    send_word(CMD_WRITE, REG_PAL_DATA, 32'd0, 7'd0);
    send_word(CMD_READ, REG_PAL_PTR, 32'd0, 7'd0);
    // vsync while disabled, then with interrupts, status clear
    send_word(CMD_VSYNC, 5'd0, 32'd0, 7'd0);
    send_word(CMD_WRITE, REG_CONTROL, 32'hFFFF_FFFF, 7'd0);
    send_word(CMD_VSYNC, 5'd0, 32'd0, 7'd0);
    send_word(CMD_READ, REG_STATUS, 32'd0, 7'd0);
    send_word(CMD_WRITE, REG_STATUS, 32'hFFFF_FFFF, 7'd0);
    // interrupt enable dropped, vsync pends, re-enable does not raise irq
    send_word(CMD_WRITE, REG_CONTROL, 32'd3, 7'd0);
    send_word(CMD_VSYNC, 5'd0, 32'd0, 7'd0);
    send_word(CMD_WRITE, REG_CONTROL, 32'd7, 7'd0);
    // largest mode placed to fill the framestore exactly
    send_word(CMD_WRITE, REG_WIDTH, 32'(MAX_MODE_WIDTH), 7'd0);
    send_word(CMD_WRITE, REG_HEIGHT, 32'(MAX_MODE_HEIGHT), 7'd0);
    send_word(CMD_WRITE, REG_DEPTH, 32'd32, 7'd0);
    send_word(CMD_WRITE, REG_STRIDE, 32'(MAX_MODE_WIDTH * 4), 7'd0);
    send_word(CMD_WRITE, REG_START,
              32'(FRAMESTORE_BYTES - MAX_MODE_WIDTH * 4 * MAX_MODE_HEIGHT), 7'd0);
    // monitor data: last byte, pointer sticks at the end, saturating pointer write
    send_word(CMD_EDID_LOAD, 5'd0, 32'hFFFF_FFFF, 7'(EDID_BYTES - 1));
    send_word(CMD_WRITE, REG_EDID_PTR, 32'(EDID_BYTES - 1), 7'd0);
    send_word(CMD_READ, REG_EDID_DATA, 32'd0, 7'd0);
    send_word(CMD_READ, REG_EDID_DATA, 32'd0, 7'd0);
    send_word(CMD_WRITE, REG_EDID_PTR, 32'hFFFF_FFFF, 7'd0);
  endtask

  // Main sequence
  initial begin : stimulus
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= CMD_READ;
    cfg_we <= 1'b0;
    cfg_index <= CFG_EDID_PRESENT;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    write_config(1'b1, $urandom, $urandom, $urandom);
    run_directed();
    drain();

    // sender idles less than the receiver; low configuration extreme
    write_config(1'b0, 32'd0, 32'd0, 32'd0);
    tx_idle_pct = 29;
    rx_idle_pct = 51;
    run_random(PHASE_WORDS);
    drain();

    // the other way round; high configuration extreme
    write_config(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    tx_idle_pct = 51;
    rx_idle_pct = 29;
    run_random(PHASE_WORDS);
    drain();

    // full rate, opening with a long receiver hold so the input stalls
    write_config(1'b1, $urandom, $urandom, $urandom);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_asks++;
    run_random(PHASE_WORDS);
    drain();

    repeat (PIPE_LATENCY * 4) @(posedge clk);
    if (mirror.errors == 0 && mirror.owed() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

>>> framebuffer_card_register_block.f
rtl/fbreg_pkg.sv
rtl/fbreg_ram.sv
rtl/framebuffer_card_register_block.sv
test/framebuffer_card_register_block_test.sv
